// ===== rtl/bisa_pkg.sv =====
// Shared types and constants of the bounded integer stack ALU.
`default_nettype none

package bisa_pkg;

   localparam int DATA_W          = 32;
   localparam int FUNC_W          = 4;
   localparam int STATUS_W        = 2;
   localparam int LIMIT_W         = 9;
   localparam int DEPTH_OUT_W     = 9;
   localparam int STACK_DEPTH_DEF = 256;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   // Instruction codes.
   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUB   = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUL   = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_DIV   = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_SWAP  = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_DROP  = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_DUP   = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 4'd8;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/bounded_integer_stack_alu_top.sv =====
// Top level of the bounded integer stack ALU: sequencer, stack store and output register.
//
// The block runs one stack-machine instruction per item on a bounded stack of
// 32-bit integers: push immediate, add, subtract, multiply, divide, swap, drop,
// duplicate and clear. An item enters on the req_ channel (req_func,
// req_operand) and gives exactly one item on the rsp_ channel (rsp_status,
// rsp_result_value, rsp_depth). The csr_ channel writes the stack limit; it is
// always ready and should only be written while no instruction is in flight.
// Push, dup, clear, the spare codes, any error and a drop that empties the
// stack go from decode straight to the response state; any other drop reads
// the new top first, swap reads and then writes back in a second state, and
// arithmetic reads and then waits on the iterative unit, whose shared adder
// does one shift-add or one restoring divide step per cycle. req_ready
// is high only while the sequencer is idle, so one instruction is worked on at
// a time. The finished item sits in an output register, so the next
// instruction is accepted while it waits; if the receiver keeps rsp_ready low,
// the following instruction holds in its final state until the register
// frees. A synchronous reset empties the stack and sets the limit to 256; the
// stack store itself is not cleared, as only entries below the depth are read.
`default_nettype none

module bounded_integer_stack_alu_top #(
   parameter int STACK_DEPTH = bisa_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic        [bisa_pkg::FUNC_W-1:0]  req_func,
   input  wire logic signed [bisa_pkg::DATA_W-1:0]  req_operand,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic        [bisa_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [bisa_pkg::DATA_W-1:0]       rsp_result_value,
   output logic        [bisa_pkg::DEPTH_OUT_W-1:0]  rsp_depth,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [bisa_pkg::LIMIT_W-1:0] csr_stack_limit
);

   import bisa_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int EXT_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_READ   = 6'b000100,
      S_ALU    = 6'b001000,
      S_SWAP2  = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [FUNC_W-1:0]    func_ff;
   logic [DATA_W-1:0]    opnd_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [DATA_W-1:0]    tos_ff, tos_in;
   logic [DATA_W-1:0]    lhs_ff, lhs_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [DATA_W-1:0]    res_ff, res_in;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [DATA_W-1:0]    rsp_value_ff;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff;
   logic                 rsp_load;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [DATA_W-1:0]    wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [DATA_W-1:0]    rd_data;

   alu_ctl_type          alu_ctl;
   logic                 alu_done;
   logic [DATA_W-1:0]    alu_result;

   logic [CNT_W-1:0]     cnt_m1;
   logic [CNT_W-1:0]     cnt_m2;
   logic [EXT_W-1:0]     cnt_ext;
   logic                 at_limit;
   logic                 below_two;
   logic                 is_empty;

   // Entries below the top live in the store; the top is also cached in tos_ff
   // so that only the second entry ever needs a memory read.
   bisa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bisa_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (rd_data),
      .b      (tos_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign cnt_m1    = cnt_ff - CNT_W'(1);
   assign cnt_m2    = cnt_ff - CNT_W'(2);
   assign cnt_ext   = EXT_W'(cnt_ff);
   // The effective limit is the smaller of the register and the store size.
   assign at_limit  = (cnt_ext >= EXT_W'(STACK_DEPTH)) || (cnt_ext >= EXT_W'(limit_ff));
   assign below_two = (cnt_ff < CNT_W'(2));
   assign is_empty  = (cnt_ff == '0);
   // The second entry is always read from here; the read data is registered in the store.
   assign rd_addr   = cnt_m2[ADDR_W-1:0];
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      tos_in      = tos_ff;
      lhs_in      = lhs_ff;
      status_in   = status_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = cnt_ff[ADDR_W-1:0];
      wr_data     = tos_ff;
      alu_ctl.start = 1'b0;
      alu_ctl.op    = ALU_ADD;

      case (func_ff)
         FUNC_SUB: alu_ctl.op = ALU_SUB;
         FUNC_MUL: alu_ctl.op = ALU_MUL;
         FUNC_DIV: alu_ctl.op = ALU_DIV;
         default:  alu_ctl.op = ALU_ADD;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            res_in    = '0;
            state_in  = S_RESP;
            case (func_ff)
               FUNC_PUSH: begin
                  if (at_limit) begin
                     status_in = ST_OVER;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = opnd_ff;
                     tos_in  = opnd_ff;
                     res_in  = opnd_ff;
                     cnt_in  = cnt_ff + CNT_W'(1);
                  end
               end
               FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV, FUNC_SWAP: begin
                  if (below_two) begin
                     status_in = ST_UNDER;
                  end else if ((func_ff == FUNC_DIV) && (tos_ff == '0)) begin
                     status_in = ST_DIVZ;
                  end else begin
                     state_in = S_READ;
                  end
               end
               FUNC_DROP: begin
                  if (is_empty) begin
                     status_in = ST_UNDER;
                  end else begin
                     res_in = tos_ff;
                     cnt_in = cnt_m1;
                     // The new top has to be fetched when one remains.
                     if (!below_two) begin
                        state_in = S_READ;
                     end
                  end
               end
               FUNC_DUP: begin
                  // Overflow takes precedence over an empty stack.
                  if (at_limit) begin
                     status_in = ST_OVER;
                  end else if (is_empty) begin
                     status_in = ST_UNDER;
                  end else begin
                     wr_en  = 1'b1;
                     res_in = tos_ff;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
               FUNC_CLEAR: begin
                  cnt_in = '0;
               end
               default: begin
                  // Unused codes report the top without touching the stack.
                  res_in = is_empty ? '0 : tos_ff;
               end
            endcase
         end
         S_READ: begin
            case (func_ff)
               FUNC_SWAP: begin
                  wr_en    = 1'b1;
                  wr_addr  = cnt_m2[ADDR_W-1:0];
                  wr_data  = tos_ff;
                  tos_in   = rd_data;
                  lhs_in   = rd_data;
                  res_in   = rd_data;
                  state_in = S_SWAP2;
               end
               FUNC_DROP: begin
                  tos_in   = rd_data;
                  state_in = S_RESP;
               end
               default: begin
                  alu_ctl.start = 1'b1;
                  state_in      = S_ALU;
               end
            endcase
         end
         S_ALU: begin
            if (alu_done) begin
               wr_en    = 1'b1;
               wr_addr  = cnt_m2[ADDR_W-1:0];
               wr_data  = alu_result;
               tos_in   = alu_result;
               res_in   = alu_result;
               cnt_in   = cnt_m1;
               state_in = S_RESP;
            end
         end
         S_SWAP2: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_m1[ADDR_W-1:0];
            wr_data  = lhs_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid) begin
            limit_ff <= csr_stack_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_valid) begin
         func_ff <= req_func;
         opnd_ff <= req_operand;
      end
      tos_ff    <= tos_in;
      lhs_ff    <= lhs_in;
      status_ff <= status_in;
      res_ff    <= res_in;
   end

   // Output register: holds a finished item until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= res_ff;
         rsp_depth_ff  <= cnt_ext[DEPTH_OUT_W-1:0];
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = $signed(rsp_value_ff);
   assign rsp_depth        = rsp_depth_ff;

`ifndef SYNTHESIS
   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond the store size");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE) && (status_in != ST_OK) |=> cnt_ff == $past(cnt_ff))
      else $error("failed instruction changed the stack depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE) && (func_ff == FUNC_PUSH) && (status_in == ST_OK)
      |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("successful push did not grow the stack by one");

   a_alu_done_expected: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == S_ALU)
      else $error("arithmetic unit finished while the sequencer was not waiting");
`endif

endmodule

`default_nettype wire

// ===== rtl/bisa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bisa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/bisa_alu.sv =====
// Iterative arithmetic unit built around one shared 33-bit adder.
`default_nettype none

module bisa_alu (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bisa_pkg::alu_ctl_type         ctl,
   input  wire logic [bisa_pkg::DATA_W-1:0]   a,
   input  wire logic [bisa_pkg::DATA_W-1:0]   b,
   output logic                               done,
   output logic      [bisa_pkg::DATA_W-1:0]   result
);

   import bisa_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_ONE  = 6'b000010,
      PH_NEGA = 6'b000100,
      PH_NEGB = 6'b001000,
      PH_ITER = 6'b010000,
      PH_NEGQ = 6'b100000
   } phase_type;

   phase_type         phase_ff;
   alu_op_type        op_ff;
   logic [DATA_W-1:0] r_ff;
   logic [DATA_W-1:0] q_ff;
   logic [DATA_W-1:0] d_ff;
   logic [STEP_W-1:0] step_ff;
   logic              neg_ff;
   logic              done_ff;

   logic [DATA_W-1:0] add_x;
   logic [DATA_W-1:0] add_y;
   logic              add_sub;
   logic [DATA_W:0]   sum;

   // Operand selection for the shared adder.
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      case (phase_ff)
         PH_ONE: begin
            add_x   = q_ff;
            add_y   = d_ff;
            add_sub = (op_ff == ALU_SUB);
         end
         PH_NEGA, PH_NEGQ: begin
            add_y   = q_ff;
            add_sub = 1'b1;
         end
         PH_NEGB: begin
            add_y   = d_ff;
            add_sub = 1'b1;
         end
         PH_ITER: begin
            if (op_ff == ALU_DIV) begin
               add_x   = {r_ff[DATA_W-2:0], q_ff[DATA_W-1]};
               add_y   = d_ff;
               add_sub = 1'b1;
            end else begin
               add_x = r_ff;
               add_y = q_ff[0] ? d_ff : '0;
            end
         end
         default: begin
            add_x   = '0;
         end
      endcase
   end

   assign sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}} + {{DATA_W{1'b0}}, add_sub};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            PH_IDLE: begin
               if (ctl.start) begin
                  op_ff   <= ctl.op;
                  q_ff    <= a;
                  d_ff    <= b;
                  r_ff    <= '0;
                  neg_ff  <= a[DATA_W-1] ^ b[DATA_W-1];
                  step_ff <= STEP_W'(DATA_W - 1);
                  if (ctl.op == ALU_DIV) begin
                     phase_ff <= PH_NEGA;
                  end else if (ctl.op == ALU_MUL) begin
                     phase_ff <= PH_ITER;
                  end else begin
                     phase_ff <= PH_ONE;
                  end
               end
            end
            PH_ONE: begin
               r_ff     <= sum[DATA_W-1:0];
               done_ff  <= 1'b1;
               phase_ff <= PH_IDLE;
            end
            PH_NEGA: begin
               if (q_ff[DATA_W-1]) begin
                  q_ff <= sum[DATA_W-1:0];
               end
               phase_ff <= PH_NEGB;
            end
            PH_NEGB: begin
               if (d_ff[DATA_W-1]) begin
                  d_ff <= sum[DATA_W-1:0];
               end
               phase_ff <= PH_ITER;
            end
            PH_ITER: begin
               if (op_ff == ALU_DIV) begin
                  // Restoring step: the carry out says the shifted remainder
                  // is at least the divisor.
                  q_ff <= {q_ff[DATA_W-2:0], sum[DATA_W]};
                  r_ff <= sum[DATA_W] ? sum[DATA_W-1:0] : add_x;
               end else begin
                  r_ff <= sum[DATA_W-1:0];
                  q_ff <= {1'b0, q_ff[DATA_W-1:1]};
                  d_ff <= {d_ff[DATA_W-2:0], 1'b0};
               end
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  if (op_ff == ALU_DIV) begin
                     phase_ff <= PH_NEGQ;
                  end else begin
                     done_ff  <= 1'b1;
                     phase_ff <= PH_IDLE;
                  end
               end
            end
            PH_NEGQ: begin
               if (neg_ff) begin
                  q_ff <= sum[DATA_W-1:0];
               end
               done_ff  <= 1'b1;
               phase_ff <= PH_IDLE;
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = (op_ff == ALU_DIV) ? q_ff : r_ff;

endmodule

`default_nettype wire

// ===== tb/stack_alu_checker.sv =====
// Checker for the bounded integer stack ALU: shadow stack, outcome queue and field comparison.
`timescale 1ns / 1ps

module stack_alu_checker #(
   parameter int STACK_DEPTH = bisa_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic        [bisa_pkg::FUNC_W-1:0]  req_func,
   input  wire logic signed [bisa_pkg::DATA_W-1:0]  req_operand,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic        [bisa_pkg::STATUS_W-1:0]    rsp_status,
   input  wire logic signed [bisa_pkg::DATA_W-1:0]      rsp_result_value,
   input  wire logic        [bisa_pkg::DEPTH_OUT_W-1:0] rsp_depth,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic        [bisa_pkg::LIMIT_W-1:0] csr_stack_limit,
   output int unsigned                              mismatch_count,
   output int unsigned                              outstanding,
   output int unsigned                              results_seen,
   output int unsigned                              ok_seen,
   output int unsigned                              over_seen,
   output int unsigned                              under_seen,
   output int unsigned                              divz_seen
);

   import bisa_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [DATA_W-1:0]      value;
      logic [DEPTH_OUT_W-1:0] depth;
   } instr_outcome_type;

   logic [DATA_W-1:0]  shadow_words [STACK_DEPTH];
   int unsigned        shadow_count = 0;
   logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;
   instr_outcome_type  instr_outcomes [$];

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("[%0t] stack ALU mismatch on %s: got %0h, expected %0h",
                  $time, what, got, want);
   endtask

   // Signed division that truncates towards zero; the most negative value over
   // minus one wraps back to itself.
   function automatic logic [DATA_W-1:0] quotient_toward_zero(input logic [DATA_W-1:0] num,
                                                               input logic [DATA_W-1:0] den);
      logic [DATA_W-1:0] mag_n;
      logic [DATA_W-1:0] mag_d;
      logic [DATA_W-1:0] q;
      mag_n = num[DATA_W-1] ? -num : num;
      mag_d = den[DATA_W-1] ? -den : den;
      q     = mag_n / mag_d;
      return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
   endfunction

   task automatic execute_on_shadow(input logic [FUNC_W-1:0] code, input logic [DATA_W-1:0] imm,
                                    output instr_outcome_type outcome);
      int unsigned       ceiling;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] val;
      ceiling = (shadow_limit < STACK_DEPTH) ? shadow_limit : STACK_DEPTH;
      outcome.status = ST_OK;
      outcome.value  = '0;
      case (code)
         FUNC_PUSH: begin
            if (shadow_count >= ceiling) begin
               outcome.status = ST_OVER;
            end else begin
               shadow_words[shadow_count] = imm;
               shadow_count++;
               outcome.value = imm;
            end
         end
         FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV, FUNC_SWAP: begin
            if (shadow_count < 2) begin
               outcome.status = ST_UNDER;
            end else begin
               rhs = shadow_words[shadow_count-1];
               lhs = shadow_words[shadow_count-2];
               if (code == FUNC_SWAP) begin
                  shadow_words[shadow_count-1] = lhs;
                  shadow_words[shadow_count-2] = rhs;
                  outcome.value = lhs;
               end else if (code == FUNC_DIV && rhs == '0) begin
                  outcome.status = ST_DIVZ;
               end else begin
                  case (code)
                     FUNC_ADD: val = lhs + rhs;
                     FUNC_SUB: val = lhs - rhs;
                     FUNC_MUL: val = lhs * rhs;
                     default:  val = quotient_toward_zero(lhs, rhs);
                  endcase
                  shadow_count--;
                  shadow_words[shadow_count-1] = val;
                  outcome.value = val;
               end
            end
         end
         FUNC_DROP: begin
            if (shadow_count == 0) begin
               outcome.status = ST_UNDER;
            end else begin
               shadow_count--;
               outcome.value = shadow_words[shadow_count];
            end
         end
         FUNC_DUP: begin
            // A full stack reports overflow even when it is also empty.
            if (shadow_count >= ceiling) begin
               outcome.status = ST_OVER;
            end else if (shadow_count == 0) begin
               outcome.status = ST_UNDER;
            end else begin
               shadow_words[shadow_count] = shadow_words[shadow_count-1];
               outcome.value = shadow_words[shadow_count-1];
               shadow_count++;
            end
         end
         FUNC_CLEAR: shadow_count = 0;
         default: begin
            // Spare codes leave the stack alone and show the top.
            if (shadow_count != 0) outcome.value = shadow_words[shadow_count-1];
         end
      endcase
      outcome.depth = shadow_count[DEPTH_OUT_W-1:0];
   endtask

   always @(posedge clock) begin
      instr_outcome_type owed;
      instr_outcome_type seen;
      if (reset) begin
         shadow_count = 0;
         shadow_limit = LIMIT_RESET;
         instr_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) shadow_limit = csr_stack_limit;
         // A result leaving at this edge always belongs to an earlier item.
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            seen = '{rsp_status, rsp_result_value, rsp_depth};
            case (seen.status)
               ST_OK:    ok_seen++;
               ST_OVER:  over_seen++;
               ST_UNDER: under_seen++;
               default:  divz_seen++;
            endcase
            if (instr_outcomes.size() == 0) begin
               report_mismatch("result with nothing outstanding", seen.value, '0);
            end else begin
               owed = instr_outcomes.pop_front();
               if (seen.status !== owed.status)
                  report_mismatch("status", DATA_W'(seen.status), DATA_W'(owed.status));
               if (seen.value !== owed.value)
                  report_mismatch("result_value", seen.value, owed.value);
               if (seen.depth !== owed.depth)
                  report_mismatch("depth", DATA_W'(seen.depth), DATA_W'(owed.depth));
            end
         end
         if (req_valid && req_ready) begin
            execute_on_shadow(req_func, req_operand, owed);
            instr_outcomes.push_back(owed);
         end
      end
      outstanding <= instr_outcomes.size();
   end

endmodule

// ===== tb/bounded_integer_stack_alu_top_tb.sv =====
// Testbench top for the bounded integer stack ALU: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module bounded_integer_stack_alu_top_tb;

   import bisa_pkg::*;

   localparam int          RESET_CYCLES     = 11;
   localparam int          LONG_HOLD_CYCLES = 400;
   // Longest instruction is a divide; allow a margin.
   localparam int          DRAIN_CYCLES     = 64;
   localparam int          SETTLE_CYCLES    = 8;
   localparam int unsigned PHASE_ITEMS      = 125;
   localparam longint      TIMEOUT_NS       = 6_000_000;

   localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
   // Function codes above clear are spare; they run to the top of the field.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_CLEAR + 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;

   logic clock;
   logic reset = 1'b1;

   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic        [FUNC_W-1:0]   req_func        = '0;
   logic signed [DATA_W-1:0]   req_operand     = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic        [STATUS_W-1:0] rsp_status;
   logic signed [DATA_W-1:0]   rsp_result_value;
   logic [DEPTH_OUT_W-1:0]     rsp_depth;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic        [LIMIT_W-1:0]  csr_stack_limit = '0;

   int unsigned mismatch_count;
   int unsigned awaiting;
   int unsigned results_seen;
   int unsigned ok_seen;
   int unsigned over_seen;
   int unsigned under_seen;
   int unsigned divz_seen;

   // Stimulus bookkeeping and the knobs that shape idling on both channels.
   int unsigned items_sent    = 0;
   int unsigned limit_writes  = 0;
   int unsigned burst_left    = 0;
   bit          steady_sender   = 1'b0;
   bit          steady_receiver = 1'b0;
   bit          hold_due        = 1'b0;

   // Stack limits visited by the random phases: tiny, middling, the full
   // stack, values beyond the stack size and zero, where nothing can be pushed.
   int unsigned phase_limits [12] = '{2, 5, 17, 256, 64, 300, 255, 1, 256, 511, 0, 128};

   bounded_integer_stack_alu_top #(
      .STACK_DEPTH(STACK_DEPTH_DEF)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_operand     (req_operand),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_result_value(rsp_result_value),
      .rsp_depth       (rsp_depth),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_stack_limit (csr_stack_limit)
   );

   stack_alu_checker #(
      .STACK_DEPTH(STACK_DEPTH_DEF)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_operand     (req_operand),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_result_value(rsp_result_value),
      .rsp_depth       (rsp_depth),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_stack_limit (csr_stack_limit),
      .mismatch_count  (mismatch_count),
      .outstanding     (awaiting),
      .results_seen    (results_seen),
      .ok_seen         (ok_seen),
      .over_seen       (over_seen),
      .under_seen      (under_seen),
      .divz_seen       (divz_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offers one instruction and waits until the block takes it. The ready
   // sampled just after the edge is the value that decided acceptance at that
   // edge. When the burst runs out valid drops for a random gap; otherwise it
   // stays high and the next call only changes the payload, so valid is never
   // lowered and raised within the same time step.
   task automatic issue(input logic [FUNC_W-1:0] code, input logic [DATA_W-1:0] imm);
      req_valid   <= 1'b1;
      req_func    <= code;
      req_operand <= imm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (!steady_sender) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clock);
            burst_left = $urandom_range(12, 0);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stops offering and waits until every accepted item has come back. The
   // first edge lets the checker's count catch up with the last acceptance.
   task automatic quiesce();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The stack limit is only rewritten with no instruction in flight.
   task automatic write_limit(input logic [LIMIT_W-1:0] lim);
      quiesce();
      csr_valid       <= 1'b1;
      csr_stack_limit <= lim;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_writes++;
   endtask

   // Draws one instruction. Pushes are weighted so that the stack wanders up
   // and down, hitting its limit and running dry; operands favour the corner
   // values now and then so that wrapping and divide by zero turn up often.
   task automatic draw_instruction(input int unsigned push_pct,
                                   output logic [FUNC_W-1:0] code,
                                   output logic [DATA_W-1:0] imm);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < push_pct) begin
         code = FUNC_PUSH;
      end else begin
         roll = $urandom_range(99, 0);
         if (roll < 12)      code = FUNC_ADD;
         else if (roll < 24) code = FUNC_SUB;
         else if (roll < 36) code = FUNC_MUL;
         else if (roll < 50) code = FUNC_DIV;
         else if (roll < 62) code = FUNC_SWAP;
         else if (roll < 78) code = FUNC_DROP;
         else if (roll < 92) code = FUNC_DUP;
         else if (roll < 96) code = FUNC_CLEAR;
         else                code = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      end
      case ($urandom_range(7, 0))
         0: begin
            case ($urandom_range(5, 0))
               0:       imm = '0;
               1:       imm = 32'd1;
               2:       imm = '1;
               3:       imm = INT_MIN;
               4:       imm = INT_MAX;
               default: imm = 32'd2;
            endcase
         end
         1:       imm = $urandom_range(16, 0) - 32'd8;
         default: imm = $urandom();
      endcase
   endtask

   task automatic run_random(input int unsigned count, input int unsigned push_pct);
      logic [FUNC_W-1:0] code;
      logic [DATA_W-1:0] imm;
      repeat (count) begin
         draw_instruction(push_pct, code, imm);
         issue(code, imm);
      end
   endtask

   // The receiver keeps its own rhythm: runs of ready and runs of stall, now
   // and then a longer stall, stretches of constant ready when asked, and on
   // request one long hold-off counted here while the sender keeps offering.
   initial begin : response_sink
      int unsigned span;
      @(posedge clock);
      forever begin
         if (hold_due) begin
            hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (steady_receiver) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            span = $urandom_range(8, 1);
            repeat (span) @(posedge clock);
            rsp_ready <= 1'b0;
            span = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 8) : $urandom_range(4, 1);
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset limit. An empty stack underflows for drop,
      // dup and arithmetic, and a spare code shows zero.
      issue(FUNC_DROP, '0);
      issue(FUNC_DUP, '0);
      issue(FUNC_ADD, '0);
      issue(FUNC_SPARE_LO, '0);
      // The largest value plus one wraps to the most negative, which divided
      // by minus one wraps back to itself.
      issue(FUNC_PUSH, INT_MAX);
      issue(FUNC_PUSH, 32'd1);
      issue(FUNC_ADD, $urandom());
      issue(FUNC_PUSH, '1);
      issue(FUNC_DIV, $urandom());
      // Division by zero leaves the stack as it was.
      issue(FUNC_PUSH, '0);
      issue(FUNC_DIV, $urandom());
      issue(FUNC_DROP, $urandom());
      issue(FUNC_DUP, $urandom());
      issue(FUNC_MUL, $urandom());
      // Minus seven over two truncates towards zero, to minus three.
      issue(FUNC_PUSH, -32'sd7);
      issue(FUNC_PUSH, 32'd2);
      issue(FUNC_DIV, $urandom());
      issue(FUNC_SUB, $urandom());
      issue(FUNC_PUSH, INT_MIN);
      issue(FUNC_SWAP, $urandom());
      issue(FUNC_SPARE_HI, $urandom());
      // With one entry holding zero, a divide underflows rather than
      // reporting division by zero.
      issue(FUNC_CLEAR, $urandom());
      issue(FUNC_PUSH, '0);
      issue(FUNC_DIV, $urandom());

      // A zero limit makes push and dup overflow, dup on an empty stack too.
      write_limit('0);
      issue(FUNC_PUSH, $urandom());
      issue(FUNC_DUP, $urandom());
      issue(FUNC_CLEAR, $urandom());
      issue(FUNC_DUP, $urandom());

      // Fill a small limit, then lower it below the depth: the entries stay,
      // growth overflows and the rest still works.
      write_limit(9'd3);
      repeat (3) issue(FUNC_PUSH, $urandom());
      issue(FUNC_PUSH, $urandom());
      issue(FUNC_DUP, $urandom());
      write_limit(9'd1);
      issue(FUNC_PUSH, $urandom());
      issue(FUNC_DROP, $urandom());
      issue(FUNC_SWAP, $urandom());
      issue(FUNC_DUP, $urandom());

      // The largest limit the register holds is cut to the stack size. Fill
      // the whole stack, so the depth reaches its top bit, then overflow it.
      write_limit('1);
      issue(FUNC_CLEAR, $urandom());
      repeat (STACK_DEPTH_DEF) issue(FUNC_PUSH, $urandom());
      issue(FUNC_PUSH, $urandom());
      issue(FUNC_DUP, $urandom());
      run_random(100, 30);

      // Random phases. Every fourth runs with no idling on either side; two
      // of the phases hold the receiver off for a long stretch while the sender
      // keeps offering, so the block backs up and stalls its input.
      foreach (phase_limits[p]) begin
         write_limit(LIMIT_W'(phase_limits[p]));
         steady_sender   = (p % 4 == 0);
         steady_receiver = (p % 4 == 0);
         if (p == 3 || p == 8) begin
            steady_sender = 1'b1;
            hold_due      = 1'b1;
         end
         run_random(PHASE_ITEMS, (phase_limits[p] > 64) ? 45 : 40);
      end
      steady_sender   = 1'b0;
      steady_receiver = 1'b0;
      write_limit(LIMIT_W'($urandom_range(STACK_DEPTH_DEF, 1)));
      run_random(100, 40);

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d instructions over %0d stack-limit settings, %0d results checked.",
               items_sent, limit_writes, results_seen);
      $display("Statuses seen: ok %0d, overflow %0d, underflow %0d, divide by zero %0d.",
               ok_seen, over_seen, under_seen, divz_seen);
      if (mismatch_count == 0 && awaiting == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Guard against a hung handshake; the limit is several times the slowest
   // correct run.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Timed out with %0d results outstanding.", awaiting);
      $display("FAIL");
      $finish;
   end

endmodule
